// File: rtl/core/r2fft_pkg.sv
// Shared types, codes, constants and the twiddle series for the radix-2 FFT engine.
`default_nettype none
package r2fft_pkg;

  // default sizing
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int TWIDDLE_BITS_DEF = 18;

  // fixed-point angle constants, Q2.30
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // input word codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // configuration register indexes
  localparam logic CFG_LOG2_POINTS  = 1'b0;
  localparam logic CFG_INVERSE_MODE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUT,
    ST_BR_RD,
    ST_BR_WI,
    ST_BR_WR,
    ST_BF_RD,
    ST_BF_TW,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_RD,
    ST_SC_WR
  } ctrl_state_t;

  typedef enum logic [2:0] {
    WSEL_SAMPLE,
    WSEL_SWAP_A,
    WSEL_SWAP_B,
    WSEL_BF_SUM,
    WSEL_BF_DIFF,
    WSEL_SCALE
  } wsel_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsel_t wr_sel;
    logic  load_out;
    logic  out_last;
  } dp_cmd_t;

  // Taylor series of cos(th), th in Q2.30, result clipped to [0, 1.0] in Q2.30
  function automatic logic [63:0] cos_series(input logic [63:0] th);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (th * th) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
    if (sum < 0) sum = 0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    return sum;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/r2fft_ctrl.sv
// Sequencer for load, bit reversal, butterfly stages, inverse scaling and readout.
`default_nettype none
module r2fft_ctrl
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_func,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic                                cfg_wr_en,
  input  wire logic                                cfg_index,
  input  wire logic [3:0]                          cfg_wdata,
  output dp_cmd_t                                  cmd,
  output logic [$clog2(MAX_POINTS)-1:0]            addr_a,
  output logic [$clog2(MAX_POINTS)-1:0]            addr_b,
  output logic [$clog2(MAX_POINTS)-1:0]            wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]            tw_k,
  output logic [$clog2($clog2(MAX_POINTS)+1)-1:0]  l_eff,
  output logic                                     inv
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(AW + 1);
  localparam int CW = AW + 1;

  ctrl_state_t state_r, state_nxt;
  logic [3:0]    log2_r, log2_nxt;
  logic          inv_r, inv_nxt;
  logic [CW-1:0] ld_pos_r, ld_pos_nxt;
  logic [CW-1:0] rd_pos_r, rd_pos_nxt;
  logic          rdy_r, rdy_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [AW-1:0] t_r, t_nxt;
  logic [LW-1:0] stg_r, stg_nxt;

  logic [LW-1:0] l_w;
  logic [CW-1:0] n_w;
  logic [CW-1:0] half_w;
  logic [AW-1:0] rev_full;
  logic [AW-1:0] rev_w;
  logic          swap_en;
  logic [LW-1:0] s1_w;
  logic [AW-1:0] hmask;
  logic [AW-1:0] a_w;
  logic [AW-1:0] b_w;
  logic          i_last;
  logic          t_last;
  logic          rd_last;
  logic [CW-1:0] ld_base;
  logic [CW-1:0] ld_inc;
  logic          in_acc;

  // clamp size to the store depth
  assign l_w   = ({1'b0, log2_r} > 5'(AW)) ? LW'(AW) : LW'(log2_r);
  assign n_w   = CW'(1) << l_w;
  assign half_w = n_w >> 1;
  assign l_eff = l_w;
  assign inv   = inv_r;

  // bit-reversed partner of the sweep index
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = i_r[AW-1-b];
    end
  end
  assign rev_w   = rev_full >> (LW'(AW) - l_w);
  assign swap_en = i_r[AW-1:0] < rev_w;

  // butterfly addresses: insert a zero at bit (stage-1), partner sets it
  assign s1_w  = stg_r - LW'(1);
  assign hmask = (AW'(1) << s1_w) - AW'(1);
  assign a_w   = ((t_r >> s1_w) << stg_r) | (t_r & hmask);
  assign b_w   = a_w | (AW'(1) << s1_w);
  assign tw_k  = (t_r & hmask) << (LW'(AW) - stg_r);

  assign i_last  = i_r == n_w - CW'(1);
  assign t_last  = t_r == AW'(half_w - CW'(1));
  assign rd_last = rd_pos_r == n_w - CW'(1);
  assign ld_base = (rdy_r || ld_pos_r >= n_w) ? '0 : ld_pos_r;
  assign ld_inc  = ld_base + CW'(1);

  // take a word only in idle and when the result register is free
  assign in_ready = (state_r == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_LOAD && ld_inc == n_w && l_w != '0) begin
          state_nxt = ST_BR_RD;
        end else if (in_acc && in_func == FUNC_READ && rdy_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT:    state_nxt = ST_IDLE;
      ST_BR_RD:  state_nxt = ST_BR_WI;
      ST_BR_WI:  state_nxt = ST_BR_WR;
      ST_BR_WR:  state_nxt = i_last ? ST_BF_RD : ST_BR_RD;
      ST_BF_RD:  state_nxt = ST_BF_TW;
      ST_BF_TW:  state_nxt = ST_BF_MUL;
      ST_BF_MUL: state_nxt = ST_BF_SUM;
      ST_BF_SUM: state_nxt = ST_BF_WA;
      ST_BF_WA:  state_nxt = ST_BF_WB;
      ST_BF_WB: begin
        if (!t_last) begin
          state_nxt = ST_BF_RD;
        end else if (stg_r != l_w) begin
          state_nxt = ST_BF_RD;
        end else begin
          state_nxt = inv_r ? ST_SC_RD : ST_IDLE;
        end
      end
      ST_SC_RD:  state_nxt = ST_SC_WR;
      ST_SC_WR:  state_nxt = i_last ? ST_IDLE : ST_SC_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    cmd.wr_sel = WSEL_SAMPLE;
    addr_a   = rd_pos_r[AW-1:0];
    addr_b   = b_w;
    wr_addr  = i_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_LOAD) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WSEL_SAMPLE;
          wr_addr    = ld_base[AW-1:0];
        end
        if (in_acc && in_func == FUNC_READ && rdy_r) begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_OUT: begin
        cmd.load_out = 1'b1;
        cmd.out_last = rd_last;
      end
      ST_BR_RD: begin
        cmd.rd_en = 1'b1;
        addr_a    = i_r[AW-1:0];
        addr_b    = rev_w;
      end
      ST_BR_WI: begin
        cmd.wr_en  = swap_en;
        cmd.wr_sel = WSEL_SWAP_B;
        wr_addr    = i_r[AW-1:0];
      end
      ST_BR_WR: begin
        cmd.wr_en  = swap_en;
        cmd.wr_sel = WSEL_SWAP_A;
        wr_addr    = rev_w;
      end
      ST_BF_RD: begin
        cmd.rd_en = 1'b1;
        addr_a    = a_w;
      end
      ST_BF_TW, ST_BF_MUL, ST_BF_SUM: begin
        addr_a = a_w;
      end
      ST_BF_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_BF_SUM;
        wr_addr    = a_w;
      end
      ST_BF_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_BF_DIFF;
        wr_addr    = b_w;
      end
      ST_SC_RD: begin
        cmd.rd_en = 1'b1;
        addr_a    = i_r[AW-1:0];
      end
      ST_SC_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WSEL_SCALE;
      end
      default: begin
        cmd.wr_en = 1'b0;
      end
    endcase
  end

  // counters, positions and configuration
  always_comb begin
    log2_nxt   = log2_r;
    inv_nxt    = inv_r;
    ld_pos_nxt = ld_pos_r;
    rd_pos_nxt = rd_pos_r;
    rdy_nxt    = rdy_r;
    i_nxt      = i_r;
    t_nxt      = t_r;
    stg_nxt    = stg_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_LOAD) begin
          rdy_nxt = 1'b0;
          if (ld_inc == n_w) begin
            ld_pos_nxt = '0;
            rd_pos_nxt = '0;
            i_nxt      = '0;
            rdy_nxt    = (l_w == '0);
          end else begin
            ld_pos_nxt = ld_inc;
          end
        end
      end
      ST_OUT: begin
        if (rd_last) begin
          rd_pos_nxt = '0;
          rdy_nxt    = 1'b0;
        end else begin
          rd_pos_nxt = rd_pos_r + CW'(1);
        end
      end
      ST_BR_WR: begin
        if (i_last) begin
          i_nxt   = '0;
          stg_nxt = LW'(1);
          t_nxt   = '0;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      ST_BF_WB: begin
        if (!t_last) begin
          t_nxt = t_r + AW'(1);
        end else begin
          t_nxt = '0;
          if (stg_r != l_w) begin
            stg_nxt = stg_r + LW'(1);
          end else begin
            i_nxt   = '0;
            rdy_nxt = !inv_r;
          end
        end
      end
      ST_SC_WR: begin
        if (i_last) begin
          i_nxt   = '0;
          rdy_nxt = 1'b1;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      default: begin
        i_nxt = i_r;
      end
    endcase
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LOG2_POINTS: begin
          log2_nxt   = cfg_wdata;
          ld_pos_nxt = '0;
          rd_pos_nxt = '0;
          rdy_nxt    = 1'b0;
        end
        CFG_INVERSE_MODE: inv_nxt = cfg_wdata[0];
        default:          inv_nxt = inv_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      log2_r   <= 4'd10;
      inv_r    <= 1'b0;
      ld_pos_r <= '0;
      rd_pos_r <= '0;
      rdy_r    <= 1'b0;
      i_r      <= '0;
      t_r      <= '0;
      stg_r    <= LW'(1);
    end else begin
      state_r  <= state_nxt;
      log2_r   <= log2_nxt;
      inv_r    <= inv_nxt;
      ld_pos_r <= ld_pos_nxt;
      rd_pos_r <= rd_pos_nxt;
      rdy_r    <= rdy_nxt;
      i_r      <= i_nxt;
      t_r      <= t_nxt;
      stg_r    <= stg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/r2fft_dp.sv
// Sample store, twiddle table, butterfly arithmetic and result register.
`default_nettype none
module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dp_cmd_t                             cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       addr_a,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       addr_b,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       tw_k,
  input  wire logic [$clog2($clog2(MAX_POINTS)+1)-1:0] l_eff,
  input  wire logic                                inv,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_re,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_im,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [31:0]                       out_result_re,
  output logic signed [31:0]                       out_result_im,
  output logic [11:0]                              out_result_index,
  output logic                                     out_last
);

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int QUARTER = MAX_POINTS / 4;
  localparam int QW      = $clog2(QUARTER + 2);
  localparam int TW      = TWIDDLE_BITS;
  localparam int TWF     = TWIDDLE_BITS - 2;
  localparam int PW      = 32 + TW;
  localparam logic signed [PW:0] RND = (PW + 1)'(1) <<< (TWF - 1);

  // complex store, two read ports and one write port
  logic [31:0] re_mem [MAX_POINTS];
  logic [31:0] im_mem [MAX_POINTS];
  logic signed [31:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic [31:0] wd_re, wd_im;

  // quarter-wave cosine table
  logic [TW-2:0] cos_tab [QUARTER + 1];
  logic [AW:0]   kx, qx, cidx, sidx;
  logic          kgt;
  logic [TW-2:0] cos_r, sin_r;
  logic          k0_r, kgt_r;
  logic signed [TW-1:0] c_s, s_s, wr_r, wi_r, wr_nxt, wi_nxt;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PW:0]   xr, xi, vr_r, vi_r;
  logic signed [32:0]   sc_re, sc_im;

  logic        out_valid_r;
  logic [31:0] out_re_r, out_im_r;
  logic [11:0] out_idx_r;
  logic        out_last_r;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [63:0] TH  = (64'd2 * PI_Q30 * 64'(k) + 64'(MAX_POINTS / 2))
                                  / 64'(MAX_POINTS);
    localparam logic [63:0] CS  = cos_series(TH);
    localparam logic [63:0] RV  = (CS + (64'd1 << (29 - TWF))) >> (30 - TWF);
    assign cos_tab[k] = RV[TW-2:0];
  end

  function automatic logic [31:0] sat32(input logic signed [PW+1:0] x);
    logic signed [PW+1:0] hi;
    logic signed [PW+1:0] lo;
    hi = (PW + 2)'(32'sh7fffffff);
    lo = -(PW + 2)'(33'sh080000000);
    if (x > hi) return 32'h7fffffff;
    if (x < lo) return 32'h80000000;
    return x[31:0];
  endfunction

  // store write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      re_mem[wr_addr] <= wd_re;
      im_mem[wr_addr] <= wd_im;
    end
    if (cmd.rd_en) begin
      a_re_r <= re_mem[addr_a];
      a_im_r <= im_mem[addr_a];
      b_re_r <= re_mem[addr_b];
      b_im_r <= im_mem[addr_b];
    end
  end

  // fold the twiddle index into the first quadrant
  assign kx   = (AW + 1)'(tw_k);
  assign qx   = (AW + 1)'(QUARTER);
  assign kgt  = kx > qx;
  assign cidx = kgt ? (qx + qx - kx) : kx;
  assign sidx = kgt ? (kx - qx) : (qx - kx);

  always_ff @(posedge clk) begin
    cos_r <= cos_tab[QW'(cidx)];
    sin_r <= cos_tab[QW'(sidx)];
    k0_r  <= (tw_k == '0);
    kgt_r <= kgt;
  end

  // signed twiddle, conjugated in forward mode
  assign c_s    = $signed({1'b0, cos_r});
  assign s_s    = $signed({1'b0, sin_r});
  assign wr_nxt = k0_r ? (TW'(1) <<< TWF) : (kgt_r ? -c_s : c_s);
  assign wi_nxt = k0_r ? '0 : (inv ? s_s : -s_s);

  // products at full width, then round back to integer
  always_ff @(posedge clk) begin
    wr_r   <= wr_nxt;
    wi_r   <= wi_nxt;
    p_rr_r <= PW'(b_re_r) * PW'(wr_r);
    p_ii_r <= PW'(b_im_r) * PW'(wi_r);
    p_ri_r <= PW'(b_re_r) * PW'(wi_r);
    p_ir_r <= PW'(b_im_r) * PW'(wr_r);
    vr_r   <= (xr + RND) >>> TWF;
    vi_r   <= (xi + RND) >>> TWF;
  end

  assign xr = (PW + 1)'(p_rr_r) - (PW + 1)'(p_ii_r);
  assign xi = (PW + 1)'(p_ri_r) + (PW + 1)'(p_ir_r);

  // inverse divide by N, round to nearest
  always_comb begin
    sc_re = (33'(a_re_r) + (33'sd1 <<< (l_eff - 1'b1))) >>> l_eff;
    sc_im = (33'(a_im_r) + (33'sd1 <<< (l_eff - 1'b1))) >>> l_eff;
    if (l_eff == '0) begin
      sc_re = 33'(a_re_r);
      sc_im = 33'(a_im_r);
    end
  end

  // write data select
  always_comb begin
    unique case (cmd.wr_sel)
      WSEL_SAMPLE: begin
        wd_re = 32'(in_sample_re);
        wd_im = 32'(in_sample_im);
      end
      WSEL_SWAP_A: begin
        wd_re = a_re_r;
        wd_im = a_im_r;
      end
      WSEL_SWAP_B: begin
        wd_re = b_re_r;
        wd_im = b_im_r;
      end
      WSEL_BF_SUM: begin
        wd_re = sat32((PW + 2)'(a_re_r) + (PW + 2)'(vr_r));
        wd_im = sat32((PW + 2)'(a_im_r) + (PW + 2)'(vi_r));
      end
      WSEL_BF_DIFF: begin
        wd_re = sat32((PW + 2)'(a_re_r) - (PW + 2)'(vr_r));
        wd_im = sat32((PW + 2)'(a_im_r) - (PW + 2)'(vi_r));
      end
      WSEL_SCALE: begin
        wd_re = sc_re[31:0];
        wd_im = sc_im[31:0];
      end
      default: begin
        wd_re = a_re_r;
        wd_im = a_im_r;
      end
    endcase
  end

  // result register: load on readout, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_re_r   <= a_re_r;
      out_im_r   <= a_im_r;
      out_idx_r  <= 12'(addr_a);
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_re    = out_re_r;
  assign out_result_im    = out_im_r;
  assign out_result_index = out_idx_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

// File: rtl/core/radix2_fft_engine.sv
// Top level: radix-2 decimation-in-time FFT with load/read word channel.
// Load word: written into the store. Read word: the store read is registered, ST_OUT loads
// the result register, and no word is taken before idle. The N-th load starts the frame:
// bit reversal, butterflies (one store write port, two writes each), inverse-only scaling.
// Synchronous active-low reset clears control state; the store is undefined until loaded.
`default_nettype none
module radix2_fft_engine
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_im,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 out_result_re,
  output logic signed [31:0]                 out_result_im,
  output logic [11:0]                        out_result_index,
  output logic                               out_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [3:0]                    cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(AW + 1);

  dp_cmd_t       cmd;
  logic [AW-1:0] addr_a, addr_b, wr_addr, tw_k;
  logic [LW-1:0] l_eff;
  logic          inv;

  r2fft_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b), .wr_addr(wr_addr),
    .tw_k(tw_k), .l_eff(l_eff), .inv(inv)
  );

  r2fft_dp #(
    .MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS), .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .addr_a(addr_a), .addr_b(addr_b), .wr_addr(wr_addr), .tw_k(tw_k),
    .l_eff(l_eff), .inv(inv),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_re(out_result_re), .out_result_im(out_result_im),
    .out_result_index(out_result_index), .out_last(out_last)
  );

  // a word is only taken when the result register can accept a new result
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result register blocked");

  // a load word never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_LOAD && !out_valid) |=> !out_valid)
    else $error("result appeared after a load word");

endmodule
`default_nettype wire
